// ===== hw/rtl/vkns_pkg.sv =====
// ----------------------------------------------------------------------------
// vkns_pkg: shared definitions for the key frame NAL scanner
// Header byte test for H.264 and HEVC, codec codes, length prefix sizes.
// ----------------------------------------------------------------------------
package vkns_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int LEN_ACCUM_BITS  = 32;

    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_HEVC = 1'b1;

    localparam logic [7:0] H264_TYPE_MASK = 8'h1f;
    localparam logic [5:0] HEVC_TYPE_MASK = 6'h3f;
    localparam logic [4:0] H264_TYPE_IDR  = 5'd5;
    localparam logic [5:0] HEVC_TYPE_LO   = 6'd16;
    localparam logic [5:0] HEVC_TYPE_HI   = 6'd21;

    typedef struct packed {
        logic accept;
        logic last;
        logic codec;
    } t_scan_ctl;

    function automatic logic hdr_is_key(input logic [7:0] hdr, input logic codec,
                                        input logic is_last);
        logic [5:0] t;
        t = hdr[6:1] & HEVC_TYPE_MASK;
        if (codec == CODEC_H264) begin
            return (hdr & H264_TYPE_MASK) == {3'b000, H264_TYPE_IDR};
        end
        if (is_last) begin
            return 1'b0;
        end
        return (t >= HEVC_TYPE_LO) && (t <= HEVC_TYPE_HI);
    endfunction

endpackage

// ===== hw/rtl/vkns_prefix_scan.sv =====
// ----------------------------------------------------------------------------
// vkns_prefix_scan: length-prefixed NAL walker
// Reads 4-byte big-endian lengths, tests each NAL header and reports a key
// frame NAL only once its payload has ended within the buffer.
// ----------------------------------------------------------------------------
module vkns_prefix_scan #(
    parameter int LENGTH_BITS = vkns_pkg::LENGTH_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vkns_pkg::t_scan_ctl i_ctl,
    input  logic [7:0]          i_byte,
    output logic                o_hit
);
    import vkns_pkg::*;

    typedef enum logic [1:0] {
        PH_LENGTH = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2,
        PH_STOP   = 2'd3
    } t_phase;

    t_phase                    r_phase, n_phase;
    logic [1:0]                r_idx, n_idx;
    logic [LEN_ACCUM_BITS-9:0] r_accum, n_accum;
    logic [LENGTH_BITS-1:0]    r_left, n_left;
    logic                      r_pending, n_pending;
    logic                      r_hit, n_hit;
    logic [LEN_ACCUM_BITS-1:0] shifted;
    logic                      fits;
    logic                      finish;
    logic                      key;

    assign shifted = {r_accum, i_byte};
    assign fits    = (shifted >> LENGTH_BITS) == '0;
    assign key     = hdr_is_key(i_byte, i_ctl.codec, i_ctl.last);

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_accum   = r_accum;
        n_left    = r_left;
        n_pending = r_pending;
        n_hit     = r_hit;
        finish    = 1'b0;
        unique case (r_phase)
            PH_LENGTH: begin
                if (r_idx == 2'd3) begin
                    n_idx   = 2'd0;
                    n_accum = '0;
                    if (shifted == '0 || !fits) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_left  = shifted[LENGTH_BITS-1:0];
                        n_phase = PH_HEADER;
                    end
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_accum = shifted[LEN_ACCUM_BITS-9:0];
                end
            end
            PH_HEADER: begin
                n_pending = key;
                n_left    = r_left - LENGTH_BITS'(1);
                if (r_left == LENGTH_BITS'(1)) begin
                    finish = 1'b1;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_left = r_left - LENGTH_BITS'(1);
                finish = (r_left == LENGTH_BITS'(1));
            end
            default: begin
            end
        endcase
        if (finish) begin
            if (n_pending) begin
                n_hit   = 1'b1;
                n_phase = PH_STOP;
            end else begin
                n_phase = PH_LENGTH;
                n_idx   = 2'd0;
                n_accum = '0;
            end
            n_pending = 1'b0;
        end
    end

    assign o_hit = n_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.accept && i_ctl.last)) begin
            r_phase   <= PH_LENGTH;
            r_idx     <= 2'd0;
            r_accum   <= '0;
            r_left    <= '0;
            r_pending <= 1'b0;
            r_hit     <= 1'b0;
        end else if (i_ctl.accept) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_accum   <= n_accum;
            r_left    <= n_left;
            r_pending <= n_pending;
            r_hit     <= n_hit;
        end
    end

    a_left_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER || r_phase == PH_BODY) |-> r_left != '0)
        else $error("payload count zero inside a NAL");

    a_idx_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_LENGTH) |-> (r_idx == 2'd0 && r_accum == '0))
        else $error("length bytes pending outside length phase");

    a_pending_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_phase == PH_BODY)
        else $error("pending key outside NAL body");

endmodule

// ===== hw/rtl/video_keyframe_nal_scanner_core.sv =====
// ----------------------------------------------------------------------------
// video_keyframe_nal_scanner_core: key frame detector over a coded buffer
// Runs an Annex B start code scan and a length-prefix scan on each byte and
// reports both at the last byte of the buffer.
// Result: registered; valid in the cycle after the last byte is taken.
// Throughput: one byte per cycle; the input stalls only while a result waits.
// Reset: synchronous active low; clears scan state, codec select and result valid.
// ----------------------------------------------------------------------------
module video_keyframe_nal_scanner_core #(
    parameter int LENGTH_BITS = vkns_pkg::LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_key_found,
    output logic       o_found_by_start_code,
    output logic       o_found_by_length_prefix
);
    import vkns_pkg::*;

    logic       r_codec;
    logic [1:0] r_zero_run, n_zero_run;
    logic       r_hdr_exp, n_hdr_exp;
    logic       r_sc_hit, n_sc_hit;
    logic       r_out_valid;
    logic       r_sc_res, r_lp_res;
    logic       accept;
    logic       lp_hit;
    t_scan_ctl  ctl;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign ctl        = '{accept: accept, last: i_last_byte, codec: r_codec};

    always_comb begin
        n_zero_run = r_zero_run;
        n_hdr_exp  = r_hdr_exp;
        n_sc_hit   = r_sc_hit;
        if (!r_sc_hit) begin
            if (r_hdr_exp) begin
                n_hdr_exp  = 1'b0;
                n_zero_run = 2'd0;
                n_sc_hit   = hdr_is_key(i_data_byte, r_codec, i_last_byte);
            end else if (i_data_byte == 8'h00) begin
                n_zero_run = r_zero_run[1] ? 2'd2 : r_zero_run + 2'd1;
            end else begin
                n_hdr_exp  = (i_data_byte == 8'h01) && r_zero_run[1];
                n_zero_run = 2'd0;
            end
        end
    end

    vkns_prefix_scan #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_prefix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_byte  (i_data_byte),
        .o_hit   (lp_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec <= CODEC_H264;
        end else if (i_cfg_we) begin
            r_codec <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_byte)) begin
            r_zero_run <= 2'd0;
            r_hdr_exp  <= 1'b0;
            r_sc_hit   <= 1'b0;
        end else if (accept) begin
            r_zero_run <= n_zero_run;
            r_hdr_exp  <= n_hdr_exp;
            r_sc_hit   <= n_sc_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_sc_res <= n_sc_hit;
            r_lp_res <= lp_hit;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_found_by_start_code    = r_sc_res;
    assign o_found_by_length_prefix = r_lp_res;
    assign o_key_found              = r_sc_res | r_lp_res;

    a_hdr_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_exp |-> r_zero_run == 2'd0)
        else $error("zero run counted across a header byte");

    a_hit_no_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sc_hit |-> !r_hdr_exp)
        else $error("header still expected after start code hit");

    a_run_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zero_run != 2'd3)
        else $error("zero run beyond saturation");

    a_clear_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (r_zero_run == 2'd0 && !r_hdr_exp && !r_sc_hit
                                     && r_out_valid))
        else $error("scan state not cleared after last byte");

endmodule

// ===== dv/tb_video_keyframe_nal_scanner_core.sv =====
// ----------------------------------------------------------------------------
// tb_video_keyframe_nal_scanner_core: self-checking bench for the NAL scanner
// Feeds coded buffers (Annex B streams, length-prefixed streams, noise and
// truncated buffers) under both codec settings. A scoreboard tracks both
// scans byte by byte and checks every verdict at the end of each buffer.
// Random gaps on input and output, plus long output hold-offs for backpressure.
// ----------------------------------------------------------------------------
module tb_video_keyframe_nal_scanner_core;
    import vkns_pkg::*;

    localparam int LEN_BITS    = LENGTH_BITS_DEF;
    localparam int BYTE_TARGET = 1900;
    localparam int PHASE_BYTES = 320;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;

    typedef enum logic [1:0] {SCAN_LEN, SCAN_HDR, SCAN_BODY, SCAN_STOP} t_scan_phase;

    typedef struct packed {
        logic key;
        logic by_start_code;
        logic by_length;
    } t_verdict;

    class keyframe_scoreboard;
        logic        codec;
        logic [1:0]  zero_run;
        logic        hdr_next;
        logic        sc_hit;
        t_scan_phase scan_ph;
        logic [1:0]  len_idx;
        logic [31:0] len_acc;
        logic [31:0] left;
        logic        pend_key;
        logic        lp_hit;
        t_verdict    verdict_q[$];
        int          errors;
        int          n_bytes;
        int          n_buffers;
        int          n_checked;
        int          n_keys;

        function new();
            codec = CODEC_H264;
            errors = 0;
            n_bytes = 0;
            n_buffers = 0;
            n_checked = 0;
            n_keys = 0;
            clear();
        endfunction

        function void clear();
            zero_run = 2'd0;
            hdr_next = 1'b0;
            sc_hit   = 1'b0;
            scan_ph  = SCAN_LEN;
            len_idx  = 2'd0;
            len_acc  = 32'd0;
            left     = 32'd0;
            pend_key = 1'b0;
            lp_hit   = 1'b0;
        endfunction

        function logic is_key_hdr(logic [7:0] h, logic is_last);
            logic [5:0] t;
            t = h[6:1];
            if (codec == CODEC_H264) begin
                return h[4:0] == H264_TYPE_IDR;
            end
            return !is_last && (t >= HEVC_TYPE_LO) && (t <= HEVC_TYPE_HI);
        endfunction

        function void end_nal();
            if (pend_key) begin
                lp_hit = 1'b1;
                scan_ph = SCAN_STOP;
            end else begin
                scan_ph = SCAN_LEN;
                len_idx = 2'd0;
                len_acc = 32'd0;
            end
            pend_key = 1'b0;
        endfunction

        function void note_byte(logic [7:0] b, logic is_last);
            t_verdict v;
            n_bytes++;
            if (!sc_hit) begin
                if (hdr_next) begin
                    hdr_next = 1'b0;
                    zero_run = 2'd0;
                    if (is_key_hdr(b, is_last)) begin
                        sc_hit = 1'b1;
                    end
                end else if (b == 8'h00) begin
                    if (zero_run < 2'd2) begin
                        zero_run++;
                    end
                end else begin
                    if (b == 8'h01 && zero_run >= 2'd2) begin
                        hdr_next = 1'b1;
                    end
                    zero_run = 2'd0;
                end
            end
            case (scan_ph)
                SCAN_LEN: begin
                    len_acc = {len_acc[23:0], b};
                    if (len_idx == 2'd3) begin
                        len_idx = 2'd0;
                        if (len_acc == 32'd0 || (len_acc >> LEN_BITS) != 32'd0) begin
                            scan_ph = SCAN_STOP;
                        end else begin
                            left = len_acc;
                            scan_ph = SCAN_HDR;
                        end
                        len_acc = 32'd0;
                    end else begin
                        len_idx++;
                    end
                end
                SCAN_HDR: begin
                    pend_key = is_key_hdr(b, is_last);
                    left--;
                    if (left == 32'd0) begin
                        end_nal();
                    end else begin
                        scan_ph = SCAN_BODY;
                    end
                end
                SCAN_BODY: begin
                    left--;
                    if (left == 32'd0) begin
                        end_nal();
                    end
                end
                default: ;
            endcase
            if (is_last) begin
                v.key = sc_hit | lp_hit;
                v.by_start_code = sc_hit;
                v.by_length = lp_hit;
                verdict_q.push_back(v);
                n_buffers++;
                if (v.key) begin
                    n_keys++;
                end
                clear();
            end
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic key, logic by_sc, logic by_lp);
            t_verdict exp_v;
            if (verdict_q.size() == 0) begin
                report("verdict with no buffer pending");
            end else begin
                exp_v = verdict_q.pop_front();
                n_checked++;
                if (key !== exp_v.key) begin
                    report($sformatf("key_found %b, expected %b", key, exp_v.key));
                end
                if (by_sc !== exp_v.by_start_code) begin
                    report($sformatf("found_by_start_code %b, expected %b",
                                     by_sc, exp_v.by_start_code));
                end
                if (by_lp !== exp_v.by_length) begin
                    report($sformatf("found_by_length_prefix %b, expected %b",
                                     by_lp, exp_v.by_length));
                end
            end
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_key_found;
    logic       o_found_by_start_code;
    logic       o_found_by_length_prefix;

    keyframe_scoreboard sb = new();
    int cycles = 0;

    video_keyframe_nal_scanner_core u_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_data              (i_cfg_data),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_data_byte             (i_data_byte),
        .i_last_byte             (i_last_byte),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_key_found             (o_key_found),
        .o_found_by_start_code   (o_found_by_start_code),
        .o_found_by_length_prefix(o_found_by_length_prefix)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_key_found, o_found_by_start_code, o_found_by_length_prefix);
        end
    end

    function automatic logic [7:0] pick_header(logic codec);
        logic [7:0] h;
        h = 8'($urandom);
        if ($urandom_range(0, 1) == 1) begin
            if (codec == CODEC_H264) begin
                h[4:0] = H264_TYPE_IDR;
            end else begin
                h[6:1] = 6'($urandom_range(HEVC_TYPE_LO, HEVC_TYPE_HI));
            end
        end
        return h;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= is_last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_byte(b, is_last);
    endtask

    task automatic send_buffer(input logic [7:0] q[$], input bit burst);
        foreach (q[i]) begin
            send_byte(q[i], i == q.size() - 1, burst);
        end
    endtask

    // drain, let the last buffer settle, then switch codec
    task automatic write_codec(input logic codec);
        i_in_valid <= 1'b0;
        while (sb.verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= codec;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.codec = codec;
    endtask

    initial begin : receiver
        int  hold;
        int  taken;
        bit  fast;
        taken = 0;
        fast = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            if (taken % 16 == 0) begin
                fast = ($urandom_range(0, 2) == 0);
            end
            if (taken == 20 || taken == 70) begin
                hold = LONG_HOLD;
            end else begin
                hold = fast ? 0 : $urandom_range(0, 8);
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                for (int c = 0; c < hold; c++) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin : stimulus
        logic [7:0]  q[$];
        logic [31:0] len;
        logic        codec;
        int          kind;
        int          r;
        int          body;
        int          cut;
        int          phase_no;
        int          target;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'h00;
        i_last_byte <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_codec(CODEC_H264);
        send_buffer('{8'h00, 8'h00, 8'h01, 8'h65, 8'hff}, 1'b0);
        send_buffer('{8'h00, 8'h00, 8'h00, 8'h01}, 1'b1);
        send_buffer('{8'h00, 8'h00, 8'h00, 8'h01, 8'h25}, 1'b0);
        send_buffer('{8'h00, 8'h00, 8'h00, 8'h00, 8'h65}, 1'b1);
        send_buffer('{8'hff}, 1'b0);
        write_codec(CODEC_HEVC);
        send_buffer('{8'h00, 8'h00, 8'h01, 8'h26}, 1'b0);

        phase_no = 0;
        while (sb.n_bytes < BYTE_TARGET) begin
            codec = phase_no[0] ? CODEC_HEVC : CODEC_H264;
            write_codec(codec);
            target = sb.n_bytes + PHASE_BYTES;
            while (sb.n_bytes < target && sb.n_bytes < BYTE_TARGET) begin
                q.delete();
                kind = $urandom_range(0, 9);
                if (kind < 4) begin
                    repeat ($urandom_range(1, 4)) begin
                        repeat ($urandom_range(2, 3)) q.push_back(8'h00);
                        q.push_back(8'h01);
                        q.push_back(pick_header(codec));
                        repeat ($urandom_range(0, 6)) q.push_back(8'($urandom_range(1, 255)));
                    end
                end else if (kind < 8) begin
                    repeat ($urandom_range(1, 3)) begin
                        r = $urandom_range(0, 9);
                        if (r == 0) begin
                            len = 32'd0;
                        end else if (r == 1) begin
                            len = $urandom;
                        end else if (r == 2) begin
                            len = $urandom_range(9, 24);
                        end else begin
                            len = $urandom_range(1, 8);
                        end
                        for (int i = 3; i >= 0; i--) q.push_back(len[8*i +: 8]);
                        if (len != 32'd0) begin
                            q.push_back(pick_header(codec));
                            body = (len > 32'd24) ? 24 : int'(len) - 1;
                            repeat (body) q.push_back(8'($urandom));
                        end
                    end
                end else begin
                    repeat ($urandom_range(1, 12)) begin
                        case ($urandom_range(0, 2))
                            0: q.push_back(8'h00);
                            1: q.push_back(8'h01);
                            default: q.push_back(8'($urandom));
                        endcase
                    end
                end
                if ($urandom_range(0, 3) == 0) begin
                    cut = $urandom_range(1, 3);
                    while (cut > 0 && q.size() > 1) begin
                        q.pop_back();
                        cut--;
                    end
                end
                send_buffer(q, $urandom_range(0, 3) == 0);
            end
            phase_no++;
        end

        i_in_valid <= 1'b0;
        while (sb.verdict_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("%0d bytes in %0d buffers over %0d codec phases; %0d verdicts checked",
                 sb.n_bytes, sb.n_buffers, phase_no + 2, sb.n_checked);
        $display("%0d buffers held a key frame, %0d mismatches", sb.n_keys, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
